### src/sha256_pkg.sv
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INITIAL_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

endpackage

### src/sha256_round.sv
module sha256_round (
   input  logic [31:0] a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in,
   input  logic [31:0] k_in,
   input  logic [31:0] w_in,
   output logic [31:0] a_out,
   output logic [31:0] e_out
);
   import sha256_pkg::*;

   logic [31:0] big1, big0, choose, major, t1, t2;

   always_comb begin
      big1   = rotr(e_in, 5'd6) ^ rotr(e_in, 5'd11) ^ rotr(e_in, 5'd25);
      choose = g_in ^ (e_in & (f_in ^ g_in));
      t1     = h_in + big1 + choose + k_in + w_in;
      big0   = rotr(a_in, 5'd2) ^ rotr(a_in, 5'd13) ^ rotr(a_in, 5'd22);
      major  = (a_in & b_in) | (a_in & c_in) | (b_in & c_in);
      t2     = big0 + major;
      a_out  = t1 + t2;
      e_out  = d_in + t1;
   end
endmodule

### src/sha256_stream_hasher.sv
// Steps: a byte that does not fill a block is accepted in S_IDLE, then written in S_BYTE; a byte
// completing a block holds the input through write, load, rounds, fold and the S_FIN decision.
// End of message: padding writes and compression, once or twice, then a read of the first chaining
// word and eight digest transactions, one per cycle when not stalled, then chaining word re-init.
// Input: a new item is taken only in S_IDLE, once earlier work is done and no digest word is held.
// Reset: synchronous; chaining words reload in S_REINIT with the input stalled, count clears.
module sha256_stream_hasher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sha256_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sha256_pkg::rsp_type  rsp_data
);
   import sha256_pkg::*;

   // One-hot controller states.
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_BYTE   = 9'b000000010, // write byte into buffer memory
      S_PAD    = 9'b000000100, // write pad / zero / length bytes
      S_LOAD   = 9'b000001000, // read 64 buffer bytes into schedule words
      S_ROUND  = 9'b000010000, // one compression round per cycle
      S_FOLD   = 9'b000100000, // read-modify-write chaining words
      S_OUT    = 9'b001000000, // emit digest words
      S_REINIT = 9'b010000000, // restore initial hash values
      S_FIN    = 9'b100000000  // decide next step after a compression
   } state_type;

   state_type state_ff, state_in;

   // Block buffer memory: one byte per entry, registered read.
   logic [7:0] buf_mem [64];
   logic       buf_we;
   logic [5:0] buf_waddr, buf_raddr;
   logic [7:0] buf_wdata, buf_rdata_ff;

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      buf_rdata_ff <= buf_mem[buf_raddr];
   end

   // Chaining word memory: eight words, registered read, one write port.
   logic [31:0] chain_mem [8];
   logic        chain_we;
   logic [2:0]  chain_waddr, chain_raddr;
   logic [31:0] chain_wdata, chain_rdata_ff;

   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[chain_waddr] <= chain_wdata;
      end
      chain_rdata_ff <= chain_mem[chain_raddr];
   end

   // Control and working registers.
   logic [63:0] count_ff, count_in;
   logic [6:0]  step_ff, step_in;    // general step counter
   logic        fin_ff, fin_in;      // message end pending
   logic        second_ff, second_in;// padding needs a second block
   logic        pending_ff, pending_in; // byte completes a block
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic        init_ff, init_in;    // chain memory loaded after reset
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;

   logic [31:0] rnd_a, rnd_e, w_new, s0, s1;

   sha256_round u_round (
      .a_in (v_ff[0]), .b_in (v_ff[1]), .c_in (v_ff[2]), .d_in (v_ff[3]),
      .e_in (v_ff[4]), .f_in (v_ff[5]), .g_in (v_ff[6]), .h_in (v_ff[7]),
      .k_in (ROUND_K[step_ff[5:0]]),
      .w_in (w_ff[0]),
      .a_out(rnd_a),
      .e_out(rnd_e)
   );

   // Sliding message schedule: w_ff[0] is the current round's word.
   always_comb begin
      s0    = rotr(w_ff[1], 5'd7) ^ rotr(w_ff[1], 5'd18) ^ (w_ff[1] >> 3);
      s1    = rotr(w_ff[14], 5'd17) ^ rotr(w_ff[14], 5'd19) ^ (w_ff[14] >> 10);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
   end

   logic [5:0] pos;
   logic [63:0] bits;
   assign pos  = count_ff[5:0];
   assign bits = {count_ff[60:0], 3'b000};

   // Padding byte for address step during S_PAD.
   logic [7:0] pad_byte;
   always_comb begin
      pad_byte = 8'h00;
      if (!second_ff && step_ff[5:0] == pos) begin
         pad_byte = PAD_BYTE;
      end
      if (step_ff[5:3] == 3'd7 && !(second_ff == 1'b0 && pos > 6'd55)) begin
         pad_byte = bits[8'(63 - 8 * step_ff[2:0]) -: 8];
      end
      if (step_ff[5:3] == 3'd7 && !second_ff && step_ff[5:0] == pos) begin
         pad_byte = PAD_BYTE;
      end
   end

   assign req_stall = !(state_ff == S_IDLE && init_ff && !rsp_valid_ff);
   logic req_take;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      fin_in       = fin_ff;
      second_in    = second_ff;
      pending_in   = pending_ff;
      w_in         = w_ff;
      v_in         = v_ff;
      init_in      = init_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      buf_we       = 1'b0;
      buf_waddr    = pos;
      buf_wdata    = byte_ff;
      buf_raddr    = step_ff[5:0];
      chain_we     = 1'b0;
      chain_waddr  = step_ff[2:0];
      chain_wdata  = INITIAL_HASH[step_ff[2:0]];
      chain_raddr  = step_ff[2:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               byte_in = req_data.data_byte;
               fin_in  = req_data.end_of_message;
               if (req_data.has_byte) begin
                  state_in = S_BYTE;
               end else if (req_data.end_of_message) begin
                  state_in  = S_PAD;
                  step_in   = 7'd0;
                  second_in = 1'b0;
               end
            end
         end
         S_BYTE: begin
            // Store byte, advance count; start compression on a full block, else pad at message end.
            buf_we     = 1'b1;
            count_in   = count_ff + 64'd1;
            step_in    = 7'd0;
            second_in  = 1'b0;
            if (pos == 6'd63) begin
               state_in   = S_LOAD;
               pending_in = 1'b1;
            end else if (fin_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            buf_waddr = step_ff[5:0];
            buf_wdata = pad_byte;
            if (second_ff || step_ff[5:0] >= pos) begin
               buf_we = 1'b1;
            end
            step_in = step_ff + 7'd1;
            if (step_ff[5:0] == 6'd63) begin
               state_in = S_LOAD;
               step_in  = 7'd0;
            end
         end
         S_LOAD: begin
            // Read one byte a cycle; shift into the schedule window and load the chain words into v.
            buf_raddr = step_ff[5:0];
            chain_raddr = step_ff[2:0];
            step_in   = step_ff + 7'd1;
            if (step_ff >= 7'd1) begin
               w_in[15] = {w_ff[15][23:0], buf_rdata_ff};
               if (step_ff[1:0] == 2'd1 && step_ff != 7'd1) begin
                  for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
                  w_in[15] = {24'd0, buf_rdata_ff};
               end
            end
            if (step_ff >= 7'd1 && step_ff <= 7'd8) begin
               v_in[step_ff[2:0] - 3'd1] = chain_rdata_ff;
            end
            if (step_ff == 7'd64) begin
               state_in = S_ROUND;
               step_in  = 7'd0;
            end
         end
         S_ROUND: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = w_new;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = rnd_e;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = rnd_a;
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd63) begin
               state_in = S_FOLD;
               step_in  = 7'd0;
            end
         end
         S_FOLD: begin
            // Read word at step, write back its sum in the next cycle.
            chain_raddr = step_ff[2:0];
            if (step_ff >= 7'd1) begin
               chain_we    = 1'b1;
               chain_waddr = 3'(step_ff - 7'd1);
               chain_wdata = chain_rdata_ff + v_ff[3'(step_ff - 7'd1)];
            end
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd8) begin
               state_in = S_FIN;
               step_in  = 7'd0;
            end
         end
         S_FIN: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               state_in   = fin_ff ? S_PAD : S_IDLE;
               second_in  = 1'b0;
            end else if (!second_ff && pos > 6'd55) begin
               second_in = 1'b1;
               state_in  = S_PAD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            chain_raddr = step_ff[2:0];
            if (!rsp_valid_ff || !rsp_stall) begin
               if (step_ff[3]) begin
                  state_in = S_REINIT;
                  step_in  = 7'd0;
                  rsp_valid_in = 1'b0;
               end else if (step_ff[4]) begin
                  rsp_in.digest_word = chain_rdata_ff;
                  rsp_in.word_index  = step_ff[2:0];
                  rsp_in.last_word   = (step_ff[2:0] == 3'd7);
                  rsp_valid_in       = 1'b1;
                  step_in            = {3'd0, step_ff[2:0] == 3'd7, step_ff[2:0] + 3'd1};
                  if (step_ff[2:0] != 3'd7) step_in[4] = 1'b1;
                  chain_raddr = step_ff[2:0] + 3'd1;
               end else begin
                  step_in = {2'd0, 1'b1, 1'b0, step_ff[2:0]};
                  rsp_valid_in = 1'b0;
               end
            end
         end
         S_REINIT: begin
            chain_we    = 1'b1;
            chain_waddr = step_ff[2:0];
            step_in     = step_ff + 7'd1;
            count_in    = 64'd0;
            fin_in      = 1'b0;
            if (step_ff == 7'd7) begin
               state_in = S_IDLE;
               init_in  = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_REINIT;
         count_ff     <= 64'd0;
         step_ff      <= 7'd0;
         fin_ff       <= 1'b0;
         second_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         fin_ff       <= fin_in;
         second_ff    <= second_in;
         pending_ff   <= pending_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      v_ff    <= v_in;
      rsp_ff  <= rsp_in;
      byte_ff <= byte_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

### src/sha256_checker.sv
module sha256_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input sha256_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input sha256_pkg::rsp_type rsp_data
);
   import sha256_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last flag mismatch");

   a_no_take_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken during digest");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.has_byte || req_data.end_of_message)
      |=> req_stall)
      else $error("input not held off after a working transaction");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=> ##1
      (!rsp_valid || rsp_data.word_index != 3'd0))
      else $error("digest order broken");
endmodule

bind sha256_stream_hasher sha256_checker u_checker (.*);

### test/sha256_digest_checker.sv
module sha256_digest_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  sha256_pkg::req_type  req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sha256_pkg::rsp_type  rsp_data,
   output int                   error_count,
   output int                   pending_words
);
   import sha256_pkg::*;

   logic [31:0] chain [8];
   logic [7:0]  block [64];
   logic [63:0] msg_bytes;
   rsp_type     digest_queue [$];

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + ROUND_K[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endtask

   task automatic absorb_item(input req_type item);
      int          fill;
      logic [63:0] bit_len;
      rsp_type     word;
      if (item.has_byte) begin
         block[msg_bytes[5:0]] = item.data_byte;
         msg_bytes++;
         if (msg_bytes[5:0] == 0) compress_block();
      end
      if (!item.end_of_message) return;
      fill = int'(msg_bytes[5:0]);
      block[fill] = PAD_BYTE;
      for (int i = fill + 1; i < 64; i++) block[i] = 8'h00;
      if (fill > 55) begin
         compress_block();
         for (int i = 0; i < 64; i++) block[i] = 8'h00;
      end
      bit_len = msg_bytes << 3;
      for (int i = 0; i < 8; i++) block[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         word.digest_word = chain[i];
         word.word_index  = 3'(i);
         word.last_word   = (i == 7);
         digest_queue.push_back(word);
      end
      for (int i = 0; i < 8; i++) chain[i] = INITIAL_HASH[i];
      msg_bytes = '0;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("digest error: %s got %h expected %h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) chain[i] = INITIAL_HASH[i];
         msg_bytes = '0;
         digest_queue.delete();
         error_count = 0;
      end else begin
         // compare before absorbing so a same-edge request cannot feed this word
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               report("unexpected word", rsp_data.digest_word, 32'h0);
            end else begin
               rsp_type want;
               want = digest_queue.pop_front();
               if (rsp_data.digest_word != want.digest_word)
                  report("digest_word", rsp_data.digest_word, want.digest_word);
               if (rsp_data.word_index != want.word_index)
                  report("word_index", 32'(rsp_data.word_index), 32'(want.word_index));
               if (rsp_data.last_word != want.last_word)
                  report("last_word", 32'(rsp_data.last_word), 32'(want.last_word));
            end
         end
         if (req_valid && !req_stall) absorb_item(req_data);
      end
      pending_words = digest_queue.size();
   end

endmodule

### test/tb_top.sv
module tb_top;
   import sha256_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      pending_words;
   int      cycle_count = 0;
   bit      hold_off = 1'b0;

   localparam int CYCLE_LIMIT = 600000;

   always #4 clock = ~clock;

   sha256_stream_hasher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   sha256_digest_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .error_count(error_count), .pending_words(pending_words)
   );

   // Guard against a hung block: fail once the cycle budget is spent.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sha256_stream_hasher: mismatch");
         $finish;
      end
   end

   // Receiver stall pattern: calm stretches, busy stretches, and a long hold-off
   // when asked, so the digest words back up and the block stalls its input.
   initial begin
      int mode;
      int span;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(5, 60);
         repeat (span) begin
            @(posedge clock);
            if (hold_off)      rsp_stall <= 1'b1;
            else if (mode == 0) rsp_stall <= 1'b0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else               rsp_stall <= ($urandom_range(0, 1) == 1);
         end
      end
   end

   // Offer one transaction and hold it until accepted; valid stays high
   // straight into the next item when no gap is due.
   task automatic send_item(input logic [7:0] value, input bit carries, input bit ends);
      req_data  <= '{data_byte: value, has_byte: carries, end_of_message: ends};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid for a random gap at the end of a burst.
   int burst_left = 0;
   task automatic maybe_gap();
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_message(input int length, input bit tail_byte);
      for (int i = 0; i < length; i++) begin
         send_item(8'($urandom), 1'b1, (tail_byte && i == length - 1));
         maybe_gap();
      end
      if (!tail_byte || length == 0) begin
         send_item(8'($urandom), 1'b0, 1'b1);
         maybe_gap();
      end
   endtask

   initial begin
      int length;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, idle item, extreme bytes, byte with end.
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'haa, 1'b1, 1'b1);
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      req_valid <= 1'b0;
      @(posedge clock);

      // Fill boundaries: 55 and 56 bytes straddle the two-block padding,
      // 64 ends exactly on a block.
      send_message(55, 1'b1);
      send_message(56, 1'b0);
      send_message(64, 1'b1);

      // Hold the receiver off while a few short messages pile up; count the
      // hold-off in its own branch so the sender keeps offering meanwhile.
      hold_off = 1'b1;
      fork
         begin
            for (int m = 0; m < 4; m++) send_message($urandom_range(0, 3), 1'b1);
            for (int m = 0; m < 3; m++) send_message($urandom_range(0, 3), 1'b0);
         end
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
      join

      // Random messages, mostly short, some noise items that do nothing.
      repeat (15) begin
         length = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 70)
                                               : $urandom_range(0, 12);
         if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_message(length, 1'($urandom));
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_words == 0)
         $display("sha256_stream_hasher: match");
      else
         $display("sha256_stream_hasher: mismatch");
      $finish;
   end

endmodule

### sim.f
src/sha256_pkg.sv
src/sha256_round.sv
src/sha256_stream_hasher.sv
src/sha256_checker.sv
test/sha256_digest_checker.sv
test/tb_top.sv
